// ===== hdl/rau_pkg.sv =====
package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_W = 2 * OPERAND_WIDTH;
   localparam int MAG_W = PROD_W + 1;
   localparam int NUM_W = 33;
   localparam int DEN_W = 31;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO_DEN = 2'd1,
      STAT_DIV_ZERO = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEL_HOLD  = 2'd0,
      SEL_LOAD  = 2'd1,
      SEL_SHIFT = 2'd2,
      SEL_DIFF  = 2'd3
   } sel_type;

   typedef struct packed {
      sel_type u_sel;
      sel_type v_sel;
   } cell_ctl_type;

   typedef struct packed {
      logic [1:0]                       operation;
      logic signed [OPERAND_WIDTH-1:0]  a_num;
      logic signed [OPERAND_WIDTH-1:0]  a_den;
      logic signed [OPERAND_WIDTH-1:0]  b_num;
      logic signed [OPERAND_WIDTH-1:0]  b_den;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] result_num;
      logic [DEN_W-1:0]        result_den;
      logic [1:0]              status;
   } rsp_type;

endpackage

// ===== hdl/rau_cell.sv =====
module rau_cell import rau_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         u_load,
   input  logic         v_load,
   input  logic         u_up,
   input  logic         v_up,
   input  logic         duv_up,
   input  logic         dvu_up,
   input  logic         buv_in,
   input  logic         bvu_in,
   output logic         u,
   output logic         v,
   output logic         duv,
   output logic         dvu,
   output logic         buv_out,
   output logic         bvu_out
);

   logic u_ff, u_in;
   logic v_ff, v_in;

   assign u = u_ff;
   assign v = v_ff;

   assign duv     = u_ff ^ v_ff ^ buv_in;
   assign buv_out = (~u_ff & v_ff) | (~(u_ff ^ v_ff) & buv_in);
   assign dvu     = v_ff ^ u_ff ^ bvu_in;
   assign bvu_out = (~v_ff & u_ff) | (~(u_ff ^ v_ff) & bvu_in);

   always_comb begin
      case (ctl.u_sel)
         SEL_HOLD:  u_in = u_ff;
         SEL_LOAD:  u_in = u_load;
         SEL_SHIFT: u_in = u_up;
         SEL_DIFF:  u_in = duv_up;
         default:   u_in = u_ff;
      endcase
      case (ctl.v_sel)
         SEL_HOLD:  v_in = v_ff;
         SEL_LOAD:  v_in = v_load;
         SEL_SHIFT: v_in = v_up;
         SEL_DIFF:  v_in = dvu_up;
         default:   v_in = v_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      v_ff <= v_in;
   end

endmodule

// ===== hdl/rau_gcd.sv =====
module rau_gcd import rau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] x,
   input  logic [MAG_W-1:0] y,
   output logic             done,
   output logic [MAG_W-1:0] g
);

   localparam int KW = $clog2(MAG_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [MAG_W-1:0] g_ff, g_in;
   cell_ctl_type     ctl;

   logic [MAG_W-1:0] u_bits, v_bits, duv_bits, dvu_bits;
   logic [MAG_W:0]   u_ext, v_ext, duv_ext, dvu_ext;
   logic [MAG_W:0]   buv_c, bvu_c;
   logic             equal;

   assign u_ext   = {1'b0, u_bits};
   assign v_ext   = {1'b0, v_bits};
   assign duv_ext = {1'b0, duv_bits};
   assign dvu_ext = {1'b0, dvu_bits};
   assign buv_c[0] = 1'b0;
   assign bvu_c[0] = 1'b0;

   genvar i;
   generate
      for (i = 0; i < MAG_W; i++) begin : g_cell
         rau_cell u_cell (
            .clock   (clock),
            .ctl     (ctl),
            .u_load  (x[i]),
            .v_load  (y[i]),
            .u_up    (u_ext[i+1]),
            .v_up    (v_ext[i+1]),
            .duv_up  (duv_ext[i+1]),
            .dvu_up  (dvu_ext[i+1]),
            .buv_in  (buv_c[i]),
            .bvu_in  (bvu_c[i]),
            .u       (u_bits[i]),
            .v       (v_bits[i]),
            .duv     (duv_bits[i]),
            .dvu     (dvu_bits[i]),
            .buv_out (buv_c[i+1]),
            .bvu_out (bvu_c[i+1])
         );
      end
   endgenerate

   assign equal = (duv_bits == '0);

   always_comb begin
      ctl     = '{u_sel: SEL_HOLD, v_sel: SEL_HOLD};
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      g_in    = g_ff;
      if (start) begin
         ctl     = '{u_sel: SEL_LOAD, v_sel: SEL_LOAD};
         busy_in = 1'b1;
         k_in    = '0;
      end else if (busy_ff) begin
         if (equal) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            g_in    = u_bits << k_ff;
         end else if (!u_bits[0] && !v_bits[0]) begin
            ctl  = '{u_sel: SEL_SHIFT, v_sel: SEL_SHIFT};
            k_in = k_ff + 1'b1;
         end else if (!u_bits[0]) begin
            ctl.u_sel = SEL_SHIFT;
         end else if (!v_bits[0]) begin
            ctl.v_sel = SEL_SHIFT;
         end else if (!buv_c[MAG_W]) begin
            ctl.u_sel = SEL_DIFF;
         end else begin
            ctl.v_sel = SEL_DIFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign done = done_ff;
   assign g    = g_ff;

endmodule

// ===== hdl/rau_div.sv =====
module rau_div import rau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] a,
   input  logic [MAG_W-1:0] b,
   input  logic [MAG_W-1:0] d,
   output logic             done,
   output logic [MAG_W-1:0] qa,
   output logic [MAG_W-1:0] qb
);

   localparam int CW = $clog2(MAG_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [MAG_W-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [MAG_W-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [MAG_W-1:0] d_ff, d_in;
   logic [MAG_W:0]   ta, tb, sa, sb;

   assign ta = {ra_ff, qa_ff[MAG_W-1]};
   assign tb = {rb_ff, qb_ff[MAG_W-1]};
   assign sa = ta - {1'b0, d_ff};
   assign sb = tb - {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      qa_in   = qa_ff;
      qb_in   = qb_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ra_in   = '0;
         rb_in   = '0;
         qa_in   = a;
         qb_in   = b;
         d_in    = d;
      end else if (busy_ff) begin
         if (!sa[MAG_W]) begin
            ra_in = sa[MAG_W-1:0];
            qa_in = {qa_ff[MAG_W-2:0], 1'b1};
         end else begin
            ra_in = ta[MAG_W-1:0];
            qa_in = {qa_ff[MAG_W-2:0], 1'b0};
         end
         if (!sb[MAG_W]) begin
            rb_in = sb[MAG_W-1:0];
            qb_in = {qb_ff[MAG_W-2:0], 1'b1};
         end else begin
            rb_in = tb[MAG_W-1:0];
            qb_in = {qb_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      qa_ff  <= qa_in;
      qb_ff  <= qb_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign qa   = qa_ff;
   assign qb   = qb_ff;

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   req_payload (req_type)
// rsp_      out        rsp_valid / rsp_stall   rsp_payload (rsp_type)
//
// One transaction at a time. An operand error or a zero result skips the reduction and division;
// otherwise the length of a transaction is set by the binary GCD loop in the cell row
// (one shift or subtract per cycle) and the 33-step serial divider.
// Reset is synchronous and clears all control state.
// A finished result waits in the output register while the next transaction is taken.
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int OW = OPERAND_WIDTH;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_SUM  = 6'b000100,
      ST_GCD  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   function automatic logic [OW-1:0] mag_of(input logic [OW-1:0] x);
      return x[OW-1] ? (~x + 1'b1) : x;
   endfunction

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [PROD_W-1:0] m1_ff, m1_in, m2_ff, m2_in, dm_ff, dm_in;
   logic             s1_ff, s1_in, s2_ff, s2_in, use2_ff, use2_in, dneg_ff, dneg_in;
   logic [MAG_W-1:0] nmag_ff, nmag_in;
   logic             neg_ff, neg_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [OW-1:0]    an_m, ad_m, bn_m, bd_m;
   logic             an_s, ad_s, bn_s, bd_s;
   op_type           op;
   logic [MAG_W-1:0] p1, p2, nm_c, nq;
   logic             nn_c, out_free;

   logic             gcd_start, gcd_done, div_start, div_done;
   logic [MAG_W-1:0] gcd_g, qa, qb;

   assign op   = op_type'(req_ff.operation);
   assign an_m = mag_of(req_ff.a_num);
   assign ad_m = mag_of(req_ff.a_den);
   assign bn_m = mag_of(req_ff.b_num);
   assign bd_m = mag_of(req_ff.b_den);
   assign an_s = req_ff.a_num[OW-1];
   assign ad_s = req_ff.a_den[OW-1];
   assign bn_s = req_ff.b_num[OW-1];
   assign bd_s = req_ff.b_den[OW-1];

   assign p1 = {1'b0, m1_ff};
   assign p2 = {1'b0, m2_ff};

   always_comb begin
      if (!use2_ff || m2_ff == '0) begin
         nm_c = p1;
         nn_c = s1_ff;
      end else if (m1_ff == '0) begin
         nm_c = p2;
         nn_c = s2_ff;
      end else if (s1_ff == s2_ff) begin
         nm_c = p1 + p2;
         nn_c = s1_ff;
      end else if (m1_ff >= m2_ff) begin
         nm_c = p1 - p2;
         nn_c = s1_ff;
      end else begin
         nm_c = p2 - p1;
         nn_c = s2_ff;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign gcd_start = (state_ff == ST_SUM) && (nm_c != '0);
   assign div_start = (state_ff == ST_GCD) && gcd_done;
   assign nq        = neg_ff ? (~qa + 1'b1) : qa;

   rau_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .x     (nm_c),
      .y     ({1'b0, dm_ff}),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   rau_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .a     (nmag_ff),
      .b     ({1'b0, dm_ff}),
      .d     (gcd_g),
      .done  (div_done),
      .qa    (qa),
      .qb    (qb)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      dm_in        = dm_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      use2_in      = use2_ff;
      dneg_in      = dneg_ff;
      nmag_in      = nmag_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            m1_in   = PROD_W'(an_m) * PROD_W'((op == OP_MUL) ? bn_m : bd_m);
            m2_in   = PROD_W'(bn_m) * PROD_W'(ad_m);
            dm_in   = PROD_W'(ad_m) * PROD_W'((op == OP_DIV) ? bn_m : bd_m);
            s1_in   = an_s ^ ((op == OP_MUL) ? bn_s : bd_s);
            s2_in   = bn_s ^ ad_s ^ (op == OP_SUB);
            use2_in = (op == OP_ADD) || (op == OP_SUB);
            dneg_in = ad_s ^ ((op == OP_DIV) ? bn_s : bd_s);
            if (req_ff.a_den == '0 || req_ff.b_den == '0) begin
               res_in   = '{result_num: '0, result_den: '0, status: STAT_ZERO_DEN};
               state_in = ST_DONE;
            end else if (op == OP_DIV && req_ff.b_num == '0) begin
               res_in   = '{result_num: '0, result_den: '0, status: STAT_DIV_ZERO};
               state_in = ST_DONE;
            end else begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (nm_c == '0) begin
               res_in   = '{result_num: '0, result_den: DEN_W'(1), status: STAT_OK};
               state_in = ST_DONE;
            end else begin
               nmag_in  = nm_c;
               neg_in   = nn_c ^ dneg_ff;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (gcd_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in.result_num = signed'(nq[NUM_W-1:0]);
               res_in.result_den = qb[DEN_W-1:0];
               res_in.status     = STAT_OK;
               state_in          = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      dm_ff   <= dm_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      use2_ff <= use2_in;
      dneg_ff <= dneg_in;
      nmag_ff <= nmag_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_gcd_done_in_gcd: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> state_ff == ST_GCD)
      else $error("gcd done outside reduction");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider done outside division");

   a_err_zero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STAT_OK |-> rsp_ff.result_den == '0)
      else $error("error result with nonzero denominator");

   a_ok_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STAT_OK |-> rsp_ff.result_den != '0)
      else $error("ok result with zero denominator");

endmodule
